FILE: rtl/core/avg_pkg.sv
// Shared constants, types and helper functions of the arc vertex generator.
// Used by the CORDIC unit, the divider, the top level and the bench.
// No dependencies.
package avg_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int CNT_LIMIT    = MAX_SEGMENTS * 100;

  // Angles in units of 2^-16 degree.
  localparam int ANG_W     = 27;
  localparam int IN_ANG_W  = 26;
  localparam logic signed [ANG_W-1:0] ANG_FULL    = 27'sd23592960;
  localparam logic signed [ANG_W-1:0] ANG_HALF    = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 27'sd5898240;

  // CORDIC datapath.
  localparam int CRD_W        = 34;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Reciprocal of 100 in Q0.19, exact for products below the count limit.
  localparam logic [12:0] RECIP_100 = 13'd5243;

  typedef logic signed [17:0] factor_t;
  typedef logic signed [31:0] coord_t;

  // Arctangent of 2^-i in 2^-16 degree.
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [3:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      4'd0:    v = 27'sd2949120;
      4'd1:    v = 27'sd1740967;
      4'd2:    v = 27'sd919879;
      4'd3:    v = 27'sd466945;
      4'd4:    v = 27'sd234379;
      4'd5:    v = 27'sd117304;
      4'd6:    v = 27'sd58666;
      4'd7:    v = 27'sd29335;
      4'd8:    v = 27'sd14668;
      4'd9:    v = 27'sd7334;
      4'd10:   v = 27'sd3667;
      4'd11:   v = 27'sd1833;
      4'd12:   v = 27'sd917;
      4'd13:   v = 27'sd458;
      4'd14:   v = 27'sd229;
      default: v = 27'sd115;
    endcase
    return v;
  endfunction

  // Round a Q.31 rotation sum back to Q16.16 and saturate to 32 bits.
  function automatic coord_t round_sat(input logic signed [51:0] acc);
    logic signed [52:0] t;
    coord_t res;
    t = {acc[51], acc} + 53'sd16384;
    t = t >>> 15;
    if (t > 53'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (t < -53'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = t[31:0];
    end
    return res;
  endfunction

  // Offset a point by the radius and convert to 1/16 pixel, rounded.
  function automatic logic [15:0] to_pixel(input coord_t p, input logic [10:0] rad);
    logic signed [33:0] t;
    logic [15:0] res;
    t = {{2{p[31]}}, p} + $signed({7'b0, rad, 16'b0}) + 34'sd2048;
    if (t < 34'sd0) begin
      res = 16'd0;
    end else if (t[33:12] > 22'd65535) begin
      res = 16'hFFFF;
    end else begin
      res = t[27:12];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/avg_in_if.sv
// Request channel of the arc vertex generator: valid/ready plus the request fields.
// No dependencies.
interface avg_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] radius_a;
  logic [9:0] radius_b;
  logic [8:0] start_deg;
  logic [9:0] end_deg;

  modport source (output valid, radius_a, radius_b, start_deg, end_deg, input ready);
  modport sink   (input valid, radius_a, radius_b, start_deg, end_deg, output ready);
endinterface

FILE: rtl/core/avg_out_if.sv
// Result channel of the arc vertex generator: valid/ready plus one vertex result.
// No dependencies.
interface avg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] vertex_x;
  logic [15:0] vertex_y;
  logic        vertex_valid;
  logic [14:0] origin_x;
  logic [14:0] origin_y;
  logic        is_arc;
  logic        last;

  modport source (output valid, vertex_x, vertex_y, vertex_valid, origin_x, origin_y,
                  is_arc, last, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_valid, origin_x, origin_y,
                  is_arc, last, output ready);
endinterface

FILE: rtl/core/arc_vertex_generator_unit.sv
// Top level of the arc vertex generator: sequencer, shared multiplier, result register.
// Depends on avg_pkg, avg_in_if, avg_out_if, avg_cordic and avg_div.
//
// The block takes one request at a time and streams one result per vertex. Setup
// computes the vertex count with two products on the shared multiplier, runs the CORDIC
// for the start angle, forms the start point with two multiplies, runs a bit-serial
// division for the step angle and then a second CORDIC run. Each vertex then takes the
// four products of the rotation on the one 19 x 33 bit multiplier. A request with an
// empty sweep returns a single result. The next request is taken as soon as the last
// result sits in the output register.
module arc_vertex_generator_unit (
  input  logic clk,
  input  logic rst_n,
  avg_in_if.sink    in_req,
  avg_out_if.source out_res
);
  import avg_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_MULP = 12'b000000000010,
    S_MULQ = 12'b000000000100,
    S_CNT  = 12'b000000001000,
    S_CS   = 12'b000000010000,
    S_PX   = 12'b000000100000,
    S_PY   = 12'b000001000000,
    S_PY2  = 12'b000010000000,
    S_DIV  = 12'b000100000000,
    S_CST  = 12'b001000000000,
    S_EMIT = 12'b010000000000,
    S_ROT  = 12'b100000000000
  } seq_state_t;

  seq_state_t         state_r;
  logic [10:0]        rad_r;
  logic signed [10:0] sweep_r;
  logic [8:0]         start_r;
  logic               arc_r;
  logic               big_r;
  logic               empty_r;
  logic [SEG_W-1:0]   cnt_r;
  logic [SEG_W-1:0]   left_r;
  coord_t             px_r, py_r;
  factor_t            sc_r, ss_r;
  logic [15:0]        peak_x_r, peak_y_r;
  logic signed [51:0] acc_r;
  logic signed [51:0] prod_r;
  logic [2:0]         ph_r;

  logic signed [18:0] mul_a;
  logic signed [32:0] mul_b;
  logic [SEG_W-1:0]   count_val;
  logic [15:0]        vx, vy, pkx_nxt, pky_nxt;
  logic               slot_free;
  logic               is_last;

  logic                cor_start, cor_done;
  logic [IN_ANG_W-1:0] cor_angle;
  factor_t             cor_cos, cor_sin;
  logic                div_start, div_done;
  logic [IN_ANG_W-1:0] div_q;

  avg_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  avg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sweep_r[9:0], 16'b0}),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign slot_free    = !out_res.valid || out_res.ready;
  assign is_last      = (left_r == SEG_W'(1));

  // Start the CORDIC on the start angle or on the step angle.
  assign cor_start = (state_r == S_CNT && count_val != '0) || (state_r == S_DIV && div_done);
  assign cor_angle = (state_r == S_DIV) ? div_q : IN_ANG_W'({start_r, 16'b0});
  assign div_start = (state_r == S_PY2);

  // Vertex count: zero for an empty sweep, saturated, or floor(product / 100) by reciprocal.
  assign count_val = (sweep_r <= 11'sd0) ? '0 :
                     big_r ? SEG_W'(MAX_SEGMENTS) : SEG_W'(prod_r[25:19]);

  // Pixel conversion and running peaks of the current vertex.
  assign vx      = to_pixel(px_r, rad_r);
  assign vy      = to_pixel(py_r, rad_r);
  assign pkx_nxt = (vx > peak_x_r) ? vx : peak_x_r;
  assign pky_nxt = (vy > peak_y_r) ? vy : peak_y_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MULP: begin
        mul_a = $signed({8'b0, rad_r});
        mul_b = 33'(sweep_r);
      end
      S_MULQ: begin
        mul_a = $signed({6'b0, RECIP_100});
        mul_b = $signed({20'b0, prod_r[12:0]});
      end
      S_PX: begin
        mul_a = 19'(cor_cos);
        mul_b = $signed({22'b0, rad_r});
      end
      S_PY: begin
        mul_a = 19'(cor_sin);
        mul_b = $signed({22'b0, rad_r});
      end
      S_ROT: begin
        case (ph_r)
          3'd0:    begin mul_a = 19'(sc_r); mul_b = 33'(px_r); end
          3'd1:    begin mul_a = 19'(ss_r); mul_b = 33'(py_r); end
          3'd2:    begin mul_a = 19'(ss_r); mul_b = 33'(px_r); end
          3'd3:    begin mul_a = 19'(sc_r); mul_b = 33'(py_r); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Registered product of the shared multiplier.
  always_ff @(posedge clk) begin
    prod_r <= 52'(mul_a) * 52'(mul_b);
  end

  // Request sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_res.valid <= 1'b0;
    end else begin
      // The result register loads on an emit and empties once taken.
      if (state_r == S_EMIT && slot_free) begin
        out_res.valid <= 1'b1;
      end else if (out_res.ready) begin
        out_res.valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            state_r <= S_MULP;
          end
        end
        S_MULP: state_r <= S_MULQ;
        S_MULQ: state_r <= S_CNT;
        S_CNT:  state_r <= (count_val == '0) ? S_EMIT : S_CS;
        S_CS: begin
          if (cor_done) begin
            state_r <= S_PX;
          end
        end
        S_PX:  state_r <= S_PY;
        S_PY:  state_r <= S_PY2;
        S_PY2: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_r <= S_CST;
          end
        end
        S_CST: begin
          if (cor_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state_r <= (empty_r || is_last) ? S_IDLE : S_ROT;
          end
        end
        S_ROT: begin
          if (ph_r == 3'd5) begin
            state_r <= S_EMIT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end

    // Datapath registers.
    case (state_r)
      S_IDLE: begin
        rad_r    <= {1'b0, in_req.radius_a} + {1'b0, in_req.radius_b};
        sweep_r  <= $signed({1'b0, in_req.end_deg}) - $signed({2'b0, in_req.start_deg});
        start_r  <= in_req.start_deg;
        arc_r    <= ({1'b0, in_req.end_deg} - {2'b0, in_req.start_deg}) != 11'd360;
        peak_x_r <= '0;
        peak_y_r <= '0;
      end
      S_MULQ: big_r <= (prod_r >= 52'(CNT_LIMIT));
      S_CNT: begin
        cnt_r   <= count_val;
        left_r  <= count_val;
        empty_r <= (count_val == '0);
      end
      S_PY:  px_r <= {prod_r[30:0], 1'b0};
      S_PY2: py_r <= {prod_r[30:0], 1'b0};
      S_CST: begin
        sc_r <= cor_cos;
        ss_r <= cor_sin;
      end
      S_EMIT: begin
        ph_r <= '0;
        if (slot_free) begin
          if (empty_r) begin
            out_res.vertex_x     <= '0;
            out_res.vertex_y     <= '0;
            out_res.vertex_valid <= 1'b0;
            out_res.origin_x     <= '0;
            out_res.origin_y     <= '0;
            out_res.is_arc       <= arc_r;
            out_res.last         <= 1'b1;
          end else begin
            out_res.vertex_x     <= vx;
            out_res.vertex_y     <= vy;
            out_res.vertex_valid <= 1'b1;
            out_res.origin_x     <= is_last ? pkx_nxt[15:1] : '0;
            out_res.origin_y     <= is_last ? pky_nxt[15:1] : '0;
            out_res.is_arc       <= is_last ? arc_r : 1'b0;
            out_res.last         <= is_last;
            peak_x_r             <= pkx_nxt;
            peak_y_r             <= pky_nxt;
            left_r               <= left_r - SEG_W'(1);
          end
        end
      end
      S_ROT: begin
        ph_r <= ph_r + 3'd1;
        case (ph_r)
          3'd1: acc_r <= prod_r;
          3'd2: acc_r <= acc_r - prod_r;
          3'd3: begin
            px_r  <= round_sat(acc_r);
            acc_r <= prod_r;
          end
          3'd4: acc_r <= acc_r + prod_r;
          3'd5: py_r  <= round_sat(acc_r);
          default: acc_r <= acc_r;
        endcase
      end
      default: ph_r <= ph_r;
    endcase
  end

endmodule

FILE: rtl/core/avg_cordic.sv
// Iterative CORDIC sine/cosine unit, one micro-rotation per cycle.
// Depends on avg_pkg for angle constants and the arctangent table.
module avg_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [avg_pkg::IN_ANG_W-1:0]  angle,
  output logic                          done,
  output avg_pkg::factor_t              cos_o,
  output avg_pkg::factor_t              sin_o
);
  import avg_pkg::*;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_RED  = 5'b00010,
    C_FOLD = 5'b00100,
    C_ITER = 5'b01000,
    C_OUT  = 5'b10000
  } crd_state_t;

  crd_state_t              state_r, state_nxt;
  logic signed [ANG_W-1:0] ang_r, ang_nxt;
  logic signed [CRD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [3:0]              idx_r, idx_nxt;
  logic                    flip_r, flip_nxt;
  logic                    done_nxt;
  factor_t                 cos_nxt, sin_nxt;
  logic signed [ANG_W-1:0] ang_wrap;
  logic signed [CRD_W-1:0] x_sh, y_sh, x_fin, y_fin;
  logic signed [18:0]      x_rnd, y_rnd;

  // Clamp a rounded 19-bit value to [-1, 1] in Q2.15.
  function automatic factor_t clamp_f(input logic signed [18:0] v);
    factor_t r;
    if (v > 19'sd32768) begin
      r = 18'sd32768;
    end else if (v < -19'sd32768) begin
      r = -18'sd32768;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  assign x_sh     = x_r >>> idx_r;
  assign y_sh     = y_r >>> idx_r;
  assign ang_wrap = (ang_r > ANG_HALF) ? (ang_r - ANG_FULL) : ang_r;
  assign x_fin    = flip_r ? -x_r : x_r;
  assign y_fin    = flip_r ? -y_r : y_r;
  assign x_rnd    = 19'((x_fin + 34'sd16384) >>> 15);
  assign y_rnd    = 19'((y_fin + 34'sd16384) >>> 15);

  // Sequencer: reduce, fold into [-90, 90], iterate, round.
  always_comb begin
    state_nxt = state_r;
    ang_nxt   = ang_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    idx_nxt   = idx_r;
    flip_nxt  = flip_r;
    done_nxt  = 1'b0;
    cos_nxt   = cos_o;
    sin_nxt   = sin_o;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          ang_nxt   = $signed({1'b0, angle});
          state_nxt = C_RED;
        end
      end
      C_RED: begin
        if (ang_r >= ANG_FULL) begin
          ang_nxt = ang_r - ANG_FULL;
        end else begin
          state_nxt = C_FOLD;
        end
      end
      C_FOLD: begin
        flip_nxt = 1'b0;
        ang_nxt  = ang_wrap;
        if (ang_wrap > ANG_QUARTER) begin
          ang_nxt  = ang_wrap - ANG_HALF;
          flip_nxt = 1'b1;
        end else if (ang_wrap < -ANG_QUARTER) begin
          ang_nxt  = ang_wrap + ANG_HALF;
          flip_nxt = 1'b1;
        end
        x_nxt     = CORDIC_GAIN;
        y_nxt     = '0;
        idx_nxt   = '0;
        state_nxt = C_ITER;
      end
      C_ITER: begin
        if (!ang_r[ANG_W-1]) begin
          x_nxt   = x_r - y_sh;
          y_nxt   = y_r + x_sh;
          ang_nxt = ang_r - atan_lut(idx_r);
        end else begin
          x_nxt   = x_r + y_sh;
          y_nxt   = y_r - x_sh;
          ang_nxt = ang_r + atan_lut(idx_r);
        end
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'(CORDIC_STEPS - 1)) begin
          state_nxt = C_OUT;
        end
      end
      C_OUT: begin
        cos_nxt   = clamp_f(x_rnd);
        sin_nxt   = clamp_f(y_rnd);
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  // Control state with reset, datapath without.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done    <= done_nxt;
    end
    ang_r  <= ang_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    idx_r  <= idx_nxt;
    flip_r <= flip_nxt;
    cos_o  <= cos_nxt;
    sin_o  <= sin_nxt;
  end

endmodule

FILE: rtl/core/avg_div.sv
// Restoring divider for the step angle, one quotient bit per cycle.
// Depends on avg_pkg for the angle and count widths.
module avg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [avg_pkg::IN_ANG_W-1:0]  dividend,
  input  logic [avg_pkg::SEG_W-1:0]     divisor,
  output logic                          done,
  output logic [avg_pkg::IN_ANG_W-1:0]  quotient
);
  import avg_pkg::*;

  localparam int BIT_CNT_W = $clog2(IN_ANG_W);

  logic                 busy_r;
  logic [BIT_CNT_W-1:0] bit_r;
  logic [SEG_W-1:0]     rem_r;
  logic [SEG_W-1:0]     dvs_r;
  logic [SEG_W:0]       rem_sh;
  logic                 fits;
  logic                 final_bit;

  assign rem_sh    = {rem_r, quotient[IN_ANG_W-1]};
  assign fits      = rem_sh >= {1'b0, dvs_r};
  assign final_bit = busy_r && !start && (bit_r == BIT_CNT_W'(IN_ANG_W - 1));

  // Shift the dividend through the remainder, one bit a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= final_bit;
      if (start) begin
        busy_r <= 1'b1;
      end else if (final_bit) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      quotient <= dividend;
      dvs_r    <= divisor;
      rem_r    <= '0;
      bit_r    <= '0;
    end else if (busy_r) begin
      rem_r    <= fits ? SEG_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[SEG_W-1:0];
      quotient <= {quotient[IN_ANG_W-2:0], fits};
      bit_r    <= bit_r + BIT_CNT_W'(1);
    end
  end

endmodule

FILE: bench/avg_bench_if.sv
// Bench-side copies of the request and result channels are not needed: the RTL
// interfaces avg_in_if and avg_out_if are used directly. This file holds the
// request and result record types used by the stimulus table. No dependencies.
`timescale 1ns / 1ps
package avg_bench_pkg;
  typedef struct packed {
    logic [9:0] radius_a;
    logic [9:0] radius_b;
    logic [8:0] start_deg;
    logic [9:0] end_deg;
  } arc_req_t;

  typedef struct packed {
    logic [15:0] vertex_x;
    logic [15:0] vertex_y;
    logic        vertex_valid;
    logic [14:0] origin_x;
    logic [14:0] origin_y;
    logic        is_arc;
    logic        last;
  } vertex_res_t;
endpackage

FILE: bench/testbench.sv
// Self-checking bench for arc_vertex_generator_unit: directed and random arc
// requests, an in-bench vertex predictor and an in-order result scoreboard.
// Depends on avg_pkg, avg_in_if, avg_out_if and avg_bench_pkg.
`timescale 1ns / 1ps
module testbench;
  import avg_pkg::*;
  import avg_bench_pkg::*;

  localparam int DIRECTED_ROWS = 14;
  localparam int RANDOM_REQS   = 280;
  localparam int LONG_HOLD     = 900;

  logic clk;
  logic rst_n;
  avg_in_if  in_req();
  avg_out_if out_res();

  arc_vertex_generator_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  vertex_res_t expected_vertices[$];
  int          error_count;
  logic        calm_phase;

  // Directed request: has_fixed marks rows whose single result is typed in.
  typedef struct {
    arc_req_t    req;
    logic        has_fixed;
    vertex_res_t fixed;
  } directed_row_t;

  directed_row_t directed_rows[DIRECTED_ROWS];

  // Arctangent steps of the sine/cosine rotation, in 2^-16 degree.
  function automatic longint atan_step(input int idx);
    longint steps[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    return steps[idx];
  endfunction

  function automatic longint shr_floor(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Append one expected result to the scoreboard queue.
  function automatic void queue_result(input vertex_res_t r);
    expected_vertices = {expected_vertices, r};
  endfunction

  // Sine and cosine of an angle in 2^-16 degree, as Q2.15 factors.
  task automatic sin_cos(input longint unsigned angle, output longint c, output longint s);
    longint a, x, y, nx, ny;
    logic   flip;
    a = longint'(angle % 64'd23592960);
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (a > 11796480) a -= 23592960;
    if (a > 5898240) begin
      a -= 11796480;
      flip = 1'b1;
    end else if (a < -5898240) begin
      a += 11796480;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (a >= 0) begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        a -= atan_step(i);
      end else begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        a += atan_step(i);
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip(shr_floor(x + 16384, 15), -32768, 32768);
    s = clip(shr_floor(y + 16384, 15), -32768, 32768);
  endtask

  function automatic longint pixel16(input longint p, input longint rad);
    return clip(shr_floor(p + (rad << 16) + 2048, 12), 0, 65535);
  endfunction

  // Queue every vertex the request should produce.
  task automatic predict_arc(input arc_req_t req);
    longint rad, sweep, count, c0, s0, cs, sn, px, py, vx, vy, nx, ny;
    longint peak_x, peak_y, step_ang;
    vertex_res_t r;
    rad = longint'(req.radius_a) + longint'(req.radius_b);
    sweep = longint'(req.end_deg) - longint'(req.start_deg);
    count = (sweep > 0) ? (rad * sweep) / 100 : 0;
    if (count > MAX_SEGMENTS) count = MAX_SEGMENTS;
    r = '0;
    r.is_arc = (sweep != 360);
    if (count == 0) begin
      r.last = 1'b1;
      queue_result(r);
      return;
    end
    sin_cos(longint'(req.start_deg) << 16, c0, s0);
    px = clip(rad * c0 * 2, -64'sd2147483648, 64'sd2147483647);
    py = clip(rad * s0 * 2, -64'sd2147483648, 64'sd2147483647);
    step_ang = (sweep << 16) / count;
    sin_cos(step_ang, cs, sn);
    peak_x = 0;
    peak_y = 0;
    for (longint k = count; k > 0; k--) begin
      vx = pixel16(px, rad);
      vy = pixel16(py, rad);
      if (vx > peak_x) peak_x = vx;
      if (vy > peak_y) peak_y = vy;
      r = '0;
      r.vertex_x = vx[15:0];
      r.vertex_y = vy[15:0];
      r.vertex_valid = 1'b1;
      if (k == 1) begin
        r.origin_x = peak_x[15:1];
        r.origin_y = peak_y[15:1];
        r.is_arc = (sweep != 360);
        r.last = 1'b1;
      end
      queue_result(r);
      nx = cs * px - sn * py;
      ny = sn * px + cs * py;
      px = clip(shr_floor(nx + 16384, 15), -64'sd2147483648, 64'sd2147483647);
      py = clip(shr_floor(ny + 16384, 15), -64'sd2147483648, 64'sd2147483647);
    end
  endtask

  function automatic arc_req_t make_req(input int ra, input int rb, input int st,
                                        input int en);
    arc_req_t q;
    q.radius_a = 10'(ra);
    q.radius_b = 10'(rb);
    q.start_deg = 9'(st);
    q.end_deg = 10'(en);
    return q;
  endfunction

  // Random request: mostly small radii and modest sweeps, sometimes anything.
  function automatic arc_req_t random_req();
    arc_req_t q;
    case ($urandom_range(0, 9))
      0: q = $bits(arc_req_t)'({$urandom, $urandom});
      1: q = make_req($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 360), $urandom_range(0, 720));
      2: q = make_req($urandom_range(0, 40), $urandom_range(0, 40),
                      $urandom_range(0, 360), $urandom_range(0, 360));
      default: begin
        q.radius_a = 10'($urandom_range(0, 60));
        q.radius_b = 10'($urandom_range(0, 60));
        q.start_deg = 9'($urandom_range(0, 360));
        q.end_deg = 10'(q.start_deg + $urandom_range(1, 360));
      end
    endcase
    return q;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Overall time limit: far above the slowest possible run.
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver stall pattern: one long hold-off, one calm stretch, random elsewhere.
  initial begin
    out_res.ready = 1'b0;
    @(posedge clk iff rst_n);
    repeat (30) @(posedge clk);
    out_res.ready <= 1'b0;
    for (int i = 0; i < LONG_HOLD; i++) @(posedge clk);
    forever begin
      @(posedge clk);
      out_res.ready <= calm_phase ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end
  end

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    vertex_res_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (expected_vertices.size() == 0) begin
        $error("unexpected vertex result");
        error_count++;
      end else begin
        want = expected_vertices.pop_front();
        if (out_res.vertex_x !== want.vertex_x) begin
          $error("vertex_x: expected %0d, got %0d", want.vertex_x, out_res.vertex_x);
          error_count++;
        end
        if (out_res.vertex_y !== want.vertex_y) begin
          $error("vertex_y: expected %0d, got %0d", want.vertex_y, out_res.vertex_y);
          error_count++;
        end
        if (out_res.vertex_valid !== want.vertex_valid) begin
          $error("vertex_valid: expected %0d, got %0d", want.vertex_valid,
                 out_res.vertex_valid);
          error_count++;
        end
        if (out_res.origin_x !== want.origin_x) begin
          $error("origin_x: expected %0d, got %0d", want.origin_x, out_res.origin_x);
          error_count++;
        end
        if (out_res.origin_y !== want.origin_y) begin
          $error("origin_y: expected %0d, got %0d", want.origin_y, out_res.origin_y);
          error_count++;
        end
        if (out_res.is_arc !== want.is_arc) begin
          $error("is_arc: expected %0d, got %0d", want.is_arc, out_res.is_arc);
          error_count++;
        end
        if (out_res.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_res.last);
          error_count++;
        end
      end
    end
  end

  // Offer one request, with random idle cycles first, and wait for acceptance.
  task automatic send_request(input arc_req_t q);
    if (!calm_phase) begin
      while ($urandom_range(0, 99) < 34) begin
        in_req.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_req.valid <= 1'b1;
    in_req.radius_a <= q.radius_a;
    in_req.radius_b <= q.radius_b;
    in_req.start_deg <= q.start_deg;
    in_req.end_deg <= q.end_deg;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    vertex_res_t empty_res;
    int waited;
    error_count = 0;
    calm_phase = 1'b0;
    in_req.valid = 1'b0;
    in_req.radius_a = '0;
    in_req.radius_b = '0;
    in_req.start_deg = '0;
    in_req.end_deg = '0;
    rst_n = 1'b0;

    // Empty sweeps have a single result that is obvious from the request.
    empty_res = '0;
    empty_res.last = 1'b1;
    empty_res.is_arc = 1'b1;
    directed_rows[0] = '{make_req(0, 0, 0, 0), 1'b1, empty_res};
    directed_rows[1] = '{make_req(1023, 1023, 360, 0), 1'b1, empty_res};
    directed_rows[2] = '{make_req(0, 0, 0, 720), 1'b1, empty_res};
    directed_rows[3] = '{make_req(1, 0, 0, 99), 1'b1, empty_res};
    directed_rows[4] = '{make_req(5, 5, 100, 100), 1'b1, empty_res};
    // Full circle, small and at the largest radius.
    directed_rows[5] = '{make_req(10, 10, 0, 360), 1'b0, empty_res};
    directed_rows[6] = '{make_req(1023, 1023, 0, 360), 1'b0, empty_res};
    // Single vertex, count saturation, angles past a full turn.
    directed_rows[7] = '{make_req(1, 0, 0, 100), 1'b0, empty_res};
    directed_rows[8] = '{make_req(682, 341, 360, 720), 1'b0, empty_res};
    directed_rows[9] = '{make_req(3, 4, 270, 720), 1'b0, empty_res};
    directed_rows[10] = '{make_req(20, 0, 90, 180), 1'b0, empty_res};
    directed_rows[11] = '{make_req(0, 1023, 179, 181), 1'b0, empty_res};
    directed_rows[12] = '{make_req(512, 256, 45, 1023), 1'b0, empty_res};
    directed_rows[13] = '{make_req(7, 9, 511, 1023), 1'b0, empty_res};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].has_fixed) queue_result(directed_rows[i].fixed);
      else predict_arc(directed_rows[i].req);
      send_request(directed_rows[i].req);
    end
    for (int i = 0; i < RANDOM_REQS; i++) begin
      arc_req_t q;
      calm_phase = (i >= 120 && i < 150);
      q = random_req();
      predict_arc(q);
      send_request(q);
    end
    calm_phase = 1'b0;
    in_req.valid <= 1'b0;

    waited = 0;
    while (expected_vertices.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (600) @(posedge clk);
    if (expected_vertices.size() != 0) begin
      $error("%0d vertex results never arrived", expected_vertices.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
